// ----- rtl/cube_map_opacity_splat_macros.svh -----
// Assertion macros for the cube map opacity splat block.
`ifndef CUBE_MAP_OPACITY_SPLAT_MACROS_SVH
`define CUBE_MAP_OPACITY_SPLAT_MACROS_SVH
`ifndef ASSERT_OFF
`define CMOS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CMOS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define CMOS_ASSERT(label, clk, rst_n, prop, msg)
`define CMOS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// ----- rtl/cmos_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cube map opacity splat package
// Operation codes, controller states, fixed field widths and the request word.
// ----------------------------------------------------------------------------
package cmos_pkg;
    localparam int CoordW = 16;
    localparam int IncW = 16;
    localparam int LightW = 13;
    localparam int CfgW = 32;
    localparam int OneQ12 = 4096;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_LEN,
        ST_DIV_U,
        ST_DIV_V,
        ST_CELLS,
        ST_RD,
        ST_RMW,
        ST_WB,
        ST_LREAD,
        ST_LWAIT,
        ST_LOUT
    } state_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CoordW-1:0] ray_x;
        logic [CoordW-1:0] ray_y;
        logic [CoordW-1:0] ray_z;
        logic [IncW-1:0]   increment;
    } req_t;
endpackage

// ----- rtl/cmos_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cube map opacity splat channel
// Valid and ready handshake carrying one payload word of a chosen type.
// ----------------------------------------------------------------------------
interface cmos_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/cmos_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cube map opacity splat divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmos_div
    import cmos_pkg::*;
#(
    parameter int NW = 32,
    parameter int DW = 18
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;
    logic [DW:0]   rem_step;
    logic [NW-1:0] quo_step;

    // One restoring step from the current registers.
    always_comb
    begin
        trial = {rem_reg[DW-1:0], quo_reg[NW-1]};
        if (trial >= {1'b0, den_reg})
        begin
            rem_step = trial - {1'b0, den_reg};
            quo_step = {quo_reg[NW-2:0], 1'b1};
        end
        else
        begin
            rem_step = trial;
            quo_step = {quo_reg[NW-2:0], 1'b0};
        end
    end

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            quo_next = quo_step;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // The final quotient is valid in the last step, even if a new start comes.
    assign done = busy_reg && (cnt_reg == CW'(1));
    assign quo = quo_step;
endmodule

// ----- rtl/cube_map_opacity_splat.sv -----
`timescale 1ns / 1ps
// A read of a nonzero ray answers after two serial divisions of one one-bit-per-cycle
// divider, each over NW = 17+clog2(FACE_SIZE+1)+F bits, and a store read. A write of such
// a ray that passes the length check also runs both divisions, then a read, modify and
// write back per cell inside the face, with ST_RD alone for a skipped cell. A clear walks
// the store one cell a cycle; one item at a time. After reset the store is cleared by the
// same walk before the first word is taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// Cube map opacity splat
// Six-face opacity store with splat writes, lighting reads and a full clear.
// ----------------------------------------------------------------------------
`include "cube_map_opacity_splat_macros.svh"
module cube_map_opacity_splat
    import cmos_pkg::*;
#(
    parameter int FACE_SIZE = 12,
    parameter int COORD_FRACTION_BITS = 8
)
(
    input  logic clk,
    input  logic rst_n,
    cmos_if.sink   req,
    cmos_if.source rsp,
    cmos_if.sink   cfg
);
    localparam int F = COORD_FRACTION_BITS;
    localparam int FaceCells = FACE_SIZE * FACE_SIZE;
    localparam int Depth = 6 * FaceCells;
    localparam int AW = $clog2(Depth);
    localparam int CellW = $clog2(FACE_SIZE + 2) + 1;
    localparam int PW = $clog2(FACE_SIZE) + F;
    // Numerator (a+m)*FACE_SIZE*2^F: a+m fits in 17 bits.
    localparam int NW = 17 + $clog2(FACE_SIZE + 1) + F;
    localparam int MW = 16;
    localparam logic [PW-1:0] PTop = PW'(FACE_SIZE * (1 << F) - 1);

    state_t state_reg, state_next;
    logic [CfgW-1:0] min_len_reg;
    req_t req_reg;
    logic [AW-1:0] addr_reg, addr_next;
    logic [2:0] face_reg;
    logic [MW-1:0] m_reg;
    logic signed [16:0] a_u_reg, a_v_reg;
    logic [PW-1:0] pu_reg, pv_reg;
    logic signed [CellW-1:0] u0_reg, v0_reg;
    logic [1:0] k_reg;
    logic [33:0] len_reg;
    logic [15:0] rdata_reg;
    logic [LightW-1:0] light_reg;
    logic rsp_valid_reg;

    logic [15:0] mem [Depth];
    logic mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0] mem_wdata;

    logic [MW-1:0] ax, ay, az;
    logic signed [16:0] sx, sy, sz;
    logic signed [16:0] a_sel;
    logic [17:0] a_plus_m;
    logic div_start, div_done;
    logic [NW-1:0] div_num, div_quo;
    logic [PW-1:0] div_clamped;
    logic signed [CellW-1:0] cu, cv;
    logic in_bounds;
    logic [16:0] sum;
    logic [AW-1:0] cell_addr, light_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= CfgW'(268435);
        end
        else if (cfg.valid && cfg.ready)
        begin
            min_len_reg <= cfg.data;
        end
    end
    assign cfg.ready = 1'b1;

    // Magnitudes of the incoming word, captured when it is taken.
    assign sx = 17'(signed'(req.data.ray_x));
    assign sy = 17'(signed'(req.data.ray_y));
    assign sz = 17'(signed'(req.data.ray_z));
    assign ax = MW'(sx < 0 ? -sx : sx);
    assign ay = MW'(sy < 0 ? -sy : sy);
    assign az = MW'(sz < 0 ? -sz : sz);

    // Divider numerator: the u side starts from the length check, the v side
    // starts in the cycle the u division finishes. The sum a+m is never negative.
    assign a_sel = (state_reg == ST_DIV_U) ? a_v_reg : a_u_reg;
    assign a_plus_m = {a_sel[16], a_sel} + {2'b00, m_reg};
    assign div_num = (NW'(a_plus_m) * NW'(FACE_SIZE)) << F;

    assign div_start = (state_reg == ST_LEN && state_next == ST_DIV_U) ||
                       (state_reg == ST_DIV_U && div_done);
    cmos_div #(.NW(NW), .DW(MW + 1)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(div_num), .den({m_reg, 1'b0}), .done(div_done), .quo(div_quo)
    );
    assign div_clamped = (div_quo > NW'(PTop)) ? PTop : div_quo[PW-1:0];

    // Current splat cell from the 2x2 walk counter.
    assign cu = u0_reg + CellW'(k_reg == 2'd1 || k_reg == 2'd2);
    assign cv = v0_reg + CellW'(k_reg[1]);
    assign in_bounds = cu >= 0 && cu < CellW'(FACE_SIZE) && cv >= 0 &&
                       cv < CellW'(FACE_SIZE);
    assign sum = {1'b0, rdata_reg} + {1'b0, req_reg.increment};
    assign cell_addr = AW'(face_reg * FaceCells + cv * FACE_SIZE + cu);
    assign light_addr = AW'(face_reg * FaceCells + (pv_reg >> F) * FACE_SIZE +
                            (pu_reg >> F));

    always_comb
    begin
        state_next = state_reg;
        addr_next = addr_reg;
        case (state_reg)
            ST_INIT:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == AW'(Depth - 1))
                begin
                    state_next = ST_IDLE;
                    addr_next = '0;
                end
            end
            ST_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    case (kind_t'(req.data.kind))
                        KIND_WRITE: state_next = ST_LEN;
                        KIND_READ: state_next = ST_LEN;
                        KIND_CLEAR:
                        begin
                            state_next = ST_INIT;
                            addr_next = '0;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LEN:
            begin
                if (m_reg == '0)
                begin
                    state_next = (req_reg.kind == KIND_READ) ? ST_LOUT : ST_IDLE;
                end
                else if (req_reg.kind == KIND_WRITE && len_reg < 34'(min_len_reg))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DIV_U;
                end
            end
            ST_DIV_U: if (div_done) state_next = ST_DIV_V;
            ST_DIV_V:
            begin
                if (div_done)
                begin
                    state_next = (req_reg.kind == KIND_READ) ? ST_LREAD : ST_CELLS;
                end
            end
            ST_CELLS: state_next = ST_RD;
            ST_RD:
            begin
                // The cell address is held for the read-modify-write that follows.
                addr_next = cell_addr;
                if (in_bounds)
                begin
                    state_next = ST_RMW;
                end
                else
                begin
                    state_next = (k_reg == 2'd3) ? ST_IDLE : ST_RD;
                end
            end
            ST_RMW: state_next = ST_WB;
            ST_WB: state_next = (k_reg == 2'd3) ? ST_IDLE : ST_RD;
            ST_LREAD:
            begin
                addr_next = light_addr;
                state_next = ST_LWAIT;
            end
            ST_LWAIT: state_next = ST_LOUT;
            ST_LOUT: if (!rsp_valid_reg || rsp.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wdata = '0;
        mem_addr = addr_reg;
        case (state_reg)
            ST_INIT: mem_we = 1'b1;
            ST_RD: mem_addr = cell_addr;
            ST_LREAD: mem_addr = light_addr;
            ST_WB:
            begin
                mem_we = 1'b1;
                mem_wdata = sum[16] ? 16'hFFFF : sum[15:0];
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    assign req.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            addr_reg <= '0;
            rsp_valid_reg <= 1'b0;
            k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg <= addr_next;
            if (state_reg == ST_LOUT && state_next == ST_IDLE)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.valid && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (state_reg == ST_CELLS)
            begin
                k_reg <= '0;
            end
            else if ((state_reg == ST_RD && !in_bounds) || state_reg == ST_WB)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg <= req.data;
            len_reg <= 34'(ax) * 34'(ax) + 34'(ay) * 34'(ay) + 34'(az) * 34'(az);
            // Face selection; ties go x, then y, then z.
            if (ax >= ay && ax >= az)
            begin
                face_reg <= (sx > 0) ? 3'd0 : 3'd1;
                m_reg <= ax;
                a_u_reg <= sz;
                a_v_reg <= sy;
            end
            else if (ay >= az)
            begin
                face_reg <= (sy > 0) ? 3'd2 : 3'd3;
                m_reg <= ay;
                a_u_reg <= sx;
                a_v_reg <= sz;
            end
            else
            begin
                face_reg <= (sz > 0) ? 3'd4 : 3'd5;
                m_reg <= az;
                a_u_reg <= sx;
                a_v_reg <= sy;
            end
        end
        if (state_reg == ST_DIV_U && div_done)
        begin
            pu_reg <= div_clamped;
            u0_reg <= CellW'(div_clamped >> F) -
                      CellW'(div_clamped[F-1] == 1'b0);
        end
        if (state_reg == ST_DIV_V && div_done)
        begin
            pv_reg <= div_clamped;
            v0_reg <= CellW'(div_clamped >> F) -
                      CellW'(div_clamped[F-1] == 1'b0);
        end
        if (state_reg == ST_LOUT && state_next == ST_IDLE)
        begin
            light_reg <= (m_reg == '0) ? LightW'(OneQ12) :
                         (rdata_reg >= 16'(OneQ12)) ? '0 :
                         LightW'(17'(OneQ12) - {1'b0, rdata_reg});
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data = light_reg;

    `CMOS_ASSERT(a_no_accept_busy, clk, rst_n,
        !(req.valid && req.ready) || state_reg == ST_IDLE, "item taken while busy")
    `CMOS_ASSERT_NEXT(a_clear_walk, clk, rst_n,
        req.valid && req.ready && req.data.kind == KIND_CLEAR, state_reg == ST_INIT,
        "clear did not start the store walk")
    `CMOS_ASSERT(a_wb_in_bounds, clk, rst_n,
        state_reg != ST_RMW || $past(in_bounds), "write back outside face")
endmodule

// ----- verif/cmos_tb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cube map opacity splat testbench package
// The channels themselves come from the RTL interface; this file only holds
// the directed stimulus row type shared by the testbench.
// ----------------------------------------------------------------------------
package cmos_tb_pkg;
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] ray_x;
        logic [15:0] ray_y;
        logic [15:0] ray_z;
        logic [15:0] increment;
        int          light_known;
    } stim_row_t;
endpackage

// ----- verif/tb_cube_map_opacity_splat.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cube map opacity splat testbench
// Drives splat writes, lighting reads, clears and no-operation words through
// the request channel, with threshold changes while idle, and checks every
// light level against a behavioural model of the opacity store.
// ----------------------------------------------------------------------------
module tb_cube_map_opacity_splat;
    import cmos_pkg::*;
    import cmos_tb_pkg::*;

    localparam int FaceSize = 12;
    localparam int FracBits = 8;
    localparam int FaceCells = FaceSize * FaceSize;
    localparam int StoreDepth = 6 * FaceCells;
    localparam int RandomWords = 1330;

    logic clk;
    logic rst_n;

    cmos_if #(.payload_t(req_t))             req ();
    cmos_if #(.payload_t(logic [LightW-1:0])) rsp ();
    cmos_if #(.payload_t(logic [CfgW-1:0]))   cfg ();

    cube_map_opacity_splat #(
        .FACE_SIZE(FaceSize),
        .COORD_FRACTION_BITS(FracBits)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source),
        .cfg(cfg.sink)
    );

    // Model copy of the store and of the length threshold.
    logic [15:0]      opacity_cells [StoreDepth];
    logic [31:0]      length_floor;
    logic [LightW-1:0] light_queue [$];
    int               fail_count;
    bit               quiet_phase;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous fixed bound on the whole run, well above the cost of clears and reads.
    initial
    begin
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Position along a face in fixed point, clamped to the last fraction step.
    function automatic int unsigned face_position(int side, int unsigned dom);
        longint unsigned num;
        longint unsigned p;
        num = longint'(side) + longint'(dom);
        p = ((num * FaceSize) << FracBits) / (2 * longint'(dom));
        if (p > (FaceSize << FracBits) - 1)
            p = (FaceSize << FracBits) - 1;
        return int'(p);
    endfunction

    // Picks the face and the two face positions; returns 0 for a zero vector.
    function automatic bit find_face(int x, int y, int z, output int face,
                                     output int unsigned pu, output int unsigned pv);
        int ax;
        int ay;
        int az;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        az = z < 0 ? -z : z;
        face = 0;
        pu = 0;
        pv = 0;
        if (ax == 0 && ay == 0 && az == 0)
            return 1'b0;
        // Ties go to x first, then y.
        if (ax >= ay && ax >= az)
        begin
            face = x > 0 ? 0 : 1;
            pu = face_position(z, ax);
            pv = face_position(y, ax);
        end
        else if (ay >= az)
        begin
            face = y > 0 ? 2 : 3;
            pu = face_position(x, ay);
            pv = face_position(z, ay);
        end
        else
        begin
            face = z > 0 ? 4 : 5;
            pu = face_position(x, az);
            pv = face_position(y, az);
        end
        return 1'b1;
    endfunction

    function automatic void bump_cell(int face, int u, int v, int unsigned inc);
        int unsigned sum;
        int idx;
        if (u < 0 || u >= FaceSize || v < 0 || v >= FaceSize)
            return;
        idx = face * FaceCells + v * FaceSize + u;
        sum = opacity_cells[idx] + inc;
        opacity_cells[idx] = sum > 65535 ? 16'hFFFF : sum[15:0];
    endfunction

    // Applies one accepted word to the model and queues any light level.
    function automatic void model_word(req_t w);
        int x;
        int y;
        int z;
        int face;
        int unsigned pu;
        int unsigned pv;
        int u0;
        int v0;
        longint unsigned len2;
        int unsigned opac;
        int unsigned light;
        x = $signed(w.ray_x);
        y = $signed(w.ray_y);
        z = $signed(w.ray_z);
        case (kind_t'(w.kind))
            KIND_WRITE:
            begin
                len2 = longint'(x * x) + longint'(y * y) + longint'(z * z);
                if (len2 >= length_floor && find_face(x, y, z, face, pu, pv))
                begin
                    // Below one half the pair starts one cell lower.
                    u0 = (pu & ((1 << FracBits) - 1)) < (1 << (FracBits - 1)) ?
                         int'(pu >> FracBits) - 1 : int'(pu >> FracBits);
                    v0 = (pv & ((1 << FracBits) - 1)) < (1 << (FracBits - 1)) ?
                         int'(pv >> FracBits) - 1 : int'(pv >> FracBits);
                    bump_cell(face, u0, v0, w.increment);
                    bump_cell(face, u0 + 1, v0, w.increment);
                    bump_cell(face, u0 + 1, v0 + 1, w.increment);
                    bump_cell(face, u0, v0 + 1, w.increment);
                end
            end
            KIND_READ:
            begin
                light = OneQ12;
                if (find_face(x, y, z, face, pu, pv))
                begin
                    opac = opacity_cells[face * FaceCells + (pv >> FracBits) * FaceSize
                                         + (pu >> FracBits)];
                    light = opac >= OneQ12 ? 0 : OneQ12 - opac;
                end
                light_queue.push_back(light[LightW-1:0]);
            end
            KIND_CLEAR:
                foreach (opacity_cells[i])
                    opacity_cells[i] = '0;
            default:
                ;
        endcase
    endfunction

    // Response checker; the sink stalls in random bursts until the quiet phase.
    initial
    begin
        logic [LightW-1:0] want;
        int gap;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                if (light_queue.size() == 0)
                begin
                    $error("light_level: no word expected, actual %0d", rsp.data);
                    fail_count++;
                end
                else
                begin
                    want = light_queue.pop_front();
                    if (rsp.data !== want)
                    begin
                        $error("light_level: expected %0d, actual %0d", want, rsp.data);
                        fail_count++;
                    end
                end
            end
            if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 16);
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                // The word seen during the stall was not taken, so nothing to check.
            end
            rsp.ready <= 1'b1;
        end
    end

    // Sends one word, holding valid until ready is seen high.
    task automatic send_word(req_t w);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data <= w;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        model_word(w);
    endtask

    // Writes the threshold only once the block has drained.
    task automatic set_floor(logic [31:0] value);
        req.valid <= 1'b0;
        wait_drained();
        cfg.valid <= 1'b1;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        length_floor = value;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (light_queue.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        // A write or clear gives no word, so allow its full walk to finish.
        repeat (1000) @(posedge clk);
    endtask

    function automatic req_t random_word();
        req_t w;
        int pick;
        pick = $urandom_range(0, 99);
        w.kind = pick < 55 ? KIND_WRITE : pick < 93 ? KIND_READ :
                 pick < 95 ? KIND_CLEAR : KIND_NOP;
        w.ray_x = 16'($urandom);
        w.ray_y = 16'($urandom);
        w.ray_z = 16'($urandom);
        // Half the words get a small x, equal x and y, or sometimes a zero z, to hit ties and edges.
        case ($urandom_range(0, 5))
            0: w.ray_x = 16'($urandom_range(0, 40));
            1: w.ray_y = w.ray_x;
            2: w.ray_z = $urandom_range(0, 3) == 0 ? 16'h0000 : w.ray_z;
            default: ;
        endcase
        w.increment = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2048));
        return w;
    endfunction

    initial
    begin
        stim_row_t rows [$];
        req_t w;
        logic [31:0] floors [4];
        int idx;
        fail_count = 0;
        quiet_phase = 1'b0;
        length_floor = 32'd268435;
        foreach (opacity_cells[i])
            opacity_cells[i] = '0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: kind, x, y, z, increment, light level or -1 for the model.
        rows = '{
            '{KIND_READ,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 4096},
            '{KIND_READ,  16'h4000, 16'h0000, 16'h0000, 16'h0000, 4096},
            '{KIND_WRITE, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, -1},
            '{KIND_WRITE, 16'h0001, 16'h0000, 16'h0000, 16'h1000, -1},
            '{KIND_WRITE, 16'h4000, 16'h0000, 16'h0000, 16'h0800, -1},
            '{KIND_READ,  16'h4000, 16'h0000, 16'h0000, 16'h0000, 2048},
            '{KIND_WRITE, 16'h4000, 16'h0000, 16'h0000, 16'hFFFF, -1},
            '{KIND_WRITE, 16'h4000, 16'h0000, 16'h0000, 16'hFFFF, -1},
            '{KIND_READ,  16'h4000, 16'h0000, 16'h0000, 16'h0000, 0},
            '{KIND_WRITE, 16'h8000, 16'h8000, 16'h8000, 16'h0100, -1},
            '{KIND_READ,  16'h8000, 16'h8000, 16'h8000, 16'h0000, -1},
            '{KIND_WRITE, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0200, -1},
            '{KIND_READ,  16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, -1},
            '{KIND_WRITE, 16'h0100, 16'h7FFF, 16'h7FFF, 16'h0300, -1},
            '{KIND_READ,  16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000, -1},
            '{KIND_WRITE, 16'h1000, 16'h2000, 16'hC000, 16'h0FFF, -1},
            '{KIND_READ,  16'h1000, 16'h2000, 16'hC000, 16'h0000, -1},
            '{KIND_WRITE, 16'hFFFF, 16'h0000, 16'h0001, 16'h0400, -1},
            '{KIND_NOP,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, -1},
            '{KIND_READ,  16'h0000, 16'hC000, 16'h3FFF, 16'h0000, -1},
            '{KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, -1},
            '{KIND_READ,  16'h4000, 16'h0000, 16'h0000, 16'h0000, 4096}
        };
        foreach (rows[i])
        begin
            w.kind = rows[i].kind;
            w.ray_x = rows[i].ray_x;
            w.ray_y = rows[i].ray_y;
            w.ray_z = rows[i].ray_z;
            w.increment = rows[i].increment;
            send_word(w);
            // Typed-in expectations do not override the model; they only cross-check it.
            if (rows[i].light_known >= 0 && light_queue.size() != 0 &&
                light_queue[$] !== rows[i].light_known[LightW-1:0])
            begin
                $error("light_level: expected %0d, actual %0d (model)",
                       rows[i].light_known, light_queue[$]);
                fail_count++;
            end
        end

        // Sender holds off until every light level has come back.
        set_floor(32'd0);
        floors = '{32'd0, 32'hC0000000, 32'd268435, 32'd1000};
        for (idx = 0; idx < RandomWords; idx++)
        begin
            if (idx % 300 == 299)
                set_floor(idx == 899 ? floors[1] : floors[(idx / 300) % 4]);
            if (idx == RandomWords - 120)
                quiet_phase = 1'b1;
            send_word(random_word());
        end
        req.valid <= 1'b0;
        wait_drained();

        if (fail_count == 0 && light_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
